@@ hdl/hpt_pkg.sv @@
package hpt_pkg;

    localparam int BucketsDef = 1021;
    localparam int EntriesDef = 1024;
    localparam int PayloadWidthDef = 64;

    localparam int PageW = 32;
    localparam int CapW = 11;
    localparam int StatusW = 3;
    localparam int ModeW = 2;
    localparam int SlotW = 10;

    localparam logic [63:0] HashAdd = 64'd1152921504606847229;
    localparam logic [63:0] HashMul = 64'd34359738641;

    typedef enum logic [ModeW-1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_FIND   = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 3'd0,
        ST_MISS     = 3'd1,
        ST_FULL     = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_DBL_DEL  = 3'd4,
        ST_RANGE    = 3'd5
    } status_t;

endpackage

@@ hdl/hpt_if.sv @@
interface hpt_req_if
    import hpt_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PayloadWidthDef
);
    logic                     valid;
    logic                     ready;
    logic [ModeW-1:0]         mode;
    logic [PageW-1:0]         page_number;
    logic [PAYLOAD_WIDTH-1:0] payload;
    logic                     write_payload;
    logic [SlotW-1:0]         slot_index;

    modport source (output valid, mode, page_number, payload, write_payload, slot_index,
                    input ready);
    modport sink (input valid, mode, page_number, payload, write_payload, slot_index,
                  output ready);
endinterface

interface hpt_rsp_if
    import hpt_pkg::*;
#(
    parameter int PAYLOAD_WIDTH = PayloadWidthDef
);
    logic                     valid;
    logic                     ready;
    logic [StatusW-1:0]       status;
    logic                     hit;
    logic [PageW-1:0]         page_out;
    logic [PAYLOAD_WIDTH-1:0] payload_out;
    logic [CapW-1:0]          used_out;

    modport source (output valid, status, hit, page_out, payload_out, used_out,
                    input ready);
    modport sink (input valid, status, hit, page_out, payload_out, used_out,
                  output ready);
endinterface

@@ hdl/hpt_hash.sv @@
module hpt_hash
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BucketsDef,
    localparam int BW = $clog2(BUCKETS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [PageW-1:0] page,
    output logic             done,
    output logic [BW-1:0]    bucket
);
    // product mod 2^64 in four 64x16 partial products; then every product bit
    // adds its constant residue 2^j mod BUCKETS, eight bits a cycle; the sum is
    // below 64*BUCKETS and six compare-subtract steps bring it under BUCKETS.
    localparam int AW = BW + 6;
    localparam logic [AW-1:0] BucketsA = AW'(BUCKETS);

    function automatic logic [64*BW-1:0] res_table();
        logic [64*BW-1:0] t;
        int r;
        t = '0;
        r = 1;
        for (int j = 0; j < 64; j++)
        begin
            t[j*BW +: BW] = BW'(r);
            r = (r * 2) % BUCKETS;
        end
        return t;
    endfunction

    localparam logic [64*BW-1:0] ResTab = res_table();

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_FOLD, H_RED} hstate_t;

    hstate_t       state_reg;
    logic [63:0]   sum_reg;
    logic [63:0]   prod_reg;
    logic [1:0]    part_reg;
    logic [2:0]    fold_reg;
    logic [2:0]    step_reg;
    logic [AW-1:0] acc_reg;
    logic [15:0]   mul_chunk;
    logic [63:0]   pp;
    logic [AW-1:0] fold_sum;
    logic [AW-1:0] sub_val;

    always_comb
    begin
        case (part_reg)
            2'd0: mul_chunk = HashMul[15:0];
            2'd1: mul_chunk = HashMul[31:16];
            2'd2: mul_chunk = HashMul[47:32];
            default: mul_chunk = HashMul[63:48];
        endcase
        pp = (64'(sum_reg) * 64'(mul_chunk)) << {part_reg, 4'd0};
        fold_sum = acc_reg;
        for (int k = 0; k < 8; k++)
        begin
            if (prod_reg[k])
                fold_sum = fold_sum + AW'(ResTab[int'({fold_reg, 3'(k)}) * BW +: BW]);
        end
        sub_val = BucketsA << step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done <= 1'b0;
            part_reg <= '0;
            fold_reg <= '0;
            step_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        sum_reg <= 64'(page) + HashAdd;
                        prod_reg <= '0;
                        part_reg <= '0;
                        state_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    prod_reg <= prod_reg + pp;
                    part_reg <= part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        acc_reg <= '0;
                        fold_reg <= '0;
                        state_reg <= H_FOLD;
                    end
                end
                H_FOLD:
                begin
                    acc_reg <= fold_sum;
                    prod_reg <= prod_reg >> 8;
                    fold_reg <= fold_reg + 3'd1;
                    if (fold_reg == 3'd7)
                    begin
                        step_reg <= 3'd5;
                        state_reg <= H_RED;
                    end
                end
                H_RED:
                begin
                    if (acc_reg >= sub_val)
                        acc_reg <= acc_reg - sub_val;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        done <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign bucket = acc_reg[BW-1:0];
endmodule

@@ hdl/hashed_page_table.sv @@
// Channel | Dir | Payload
// req     | in  | mode, page_number, payload, write_payload, slot_index
// rsp     | out | status, hit, page_out, payload_out, used_out
// cfg     | in  | cfg_we, cfg_wdata (capacity)
// Insert: hash start, then the hash unit's multiply, fold and reduce steps,
// bucket head read, link and post. Delete and find read the head likewise,
// then walk the chain link by link. Slot reads post after the entry read, and
// full inserts at once. After reset a clearing pass empties the bucket heads; no
// beat is accepted then. One item at a time; a finished result waits in the
// output register until taken, and the input stalls meanwhile.
module hashed_page_table
    import hpt_pkg::*;
#(
    parameter int BUCKETS = BucketsDef,
    parameter int ENTRIES = EntriesDef,
    parameter int PAYLOAD_WIDTH = PayloadWidthDef
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CapW-1:0]  cfg_wdata,
    hpt_req_if.sink          req,
    hpt_rsp_if.source        rsp
);
    localparam int BW = $clog2(BUCKETS);
    localparam int EW = $clog2(ENTRIES);
    localparam int PW = EW + 1;
    localparam logic [PW-1:0] Nil = PW'(ENTRIES);
    localparam logic [BW-1:0] LastB = BW'(BUCKETS - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD, S_HEADW, S_ENT, S_ENTW, S_INS,
        S_READW, S_OUT
    } state_t;

    logic [PW-1:0]            heads_mem [BUCKETS];
    logic [PageW-1:0]         page_mem  [ENTRIES];
    logic [PAYLOAD_WIDTH-1:0] pay_mem   [ENTRIES];
    logic [PW-1:0]            next_mem  [ENTRIES];

    state_t                   state_reg;
    logic [BW-1:0]            clr_reg;
    logic [CapW-1:0]          cap_reg;
    logic [PW-1:0]            used_reg;
    logic [EW-1:0]            recyc_reg;
    logic                     recyc_vld_reg;
    logic [ModeW-1:0]         mode_reg;
    logic [PageW-1:0]         page_reg;
    logic [PAYLOAD_WIDTH-1:0] pay_reg;
    logic                     wr_reg;
    logic [SlotW-1:0]         sidx_reg;
    logic [BW-1:0]            bkt_reg;
    logic [PW-1:0]            cur_reg;
    logic [PW-1:0]            prev_reg;

    // memory ports
    logic                     h_we, e_we, n_we, h_re, e_re;
    logic [BW-1:0]            h_addr;
    logic [PW-1:0]            h_wd;
    logic [EW-1:0]            e_raddr, e_waddr, n_waddr;
    logic [PW-1:0]            n_wd;
    logic                     pw_we;
    logic [PW-1:0]            h_rd, n_rd;
    logic [PageW-1:0]         pg_rd;
    logic [PAYLOAD_WIDTH-1:0] py_rd;

    logic                     hash_start, hash_done;
    logic [BW-1:0]            hash_bkt;
    logic [PW-1:0]            limit;
    logic                     accept;

    hpt_hash #(.BUCKETS(BUCKETS)) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .page   (page_reg),
        .done   (hash_done),
        .bucket (hash_bkt)
    );

    always_ff @(posedge clk)
    begin
        if (h_we)
            heads_mem[h_addr] <= h_wd;
        if (h_re)
            h_rd <= heads_mem[h_addr];
        if (e_we)
            page_mem[e_waddr] <= page_reg;
        if (pw_we)
            pay_mem[e_waddr] <= pay_reg;
        if (n_we)
            next_mem[n_waddr] <= n_wd;
        if (e_re)
        begin
            pg_rd <= page_mem[e_raddr];
            py_rd <= pay_mem[e_raddr];
            n_rd <= next_mem[e_raddr];
        end
    end

    assign limit = (32'(cap_reg) < ENTRIES) ? PW'(cap_reg) : Nil;
    assign req.ready = (state_reg == S_IDLE) && !rsp.valid;
    assign accept = req.valid && req.ready;
    assign hash_start = (state_reg == S_HASH);

    logic [EW-1:0] ins_slot;
    assign ins_slot = recyc_vld_reg ? recyc_reg : used_reg[EW-1:0];

    always_comb
    begin
        h_we = 1'b0;
        h_re = 1'b0;
        h_addr = bkt_reg;
        h_wd = Nil;
        e_we = 1'b0;
        pw_we = 1'b0;
        n_we = 1'b0;
        e_re = 1'b0;
        e_raddr = cur_reg[EW-1:0];
        e_waddr = ins_slot;
        n_waddr = ins_slot;
        n_wd = h_rd;
        case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1;
                h_addr = clr_reg;
            end
            S_IDLE:
            begin
                e_re = 1'b1;
                e_raddr = req.slot_index[EW-1:0];
            end
            S_HEAD:
            begin
                // the read that counts is the one on the cycle done is high
                h_re = 1'b1;
                h_addr = hash_bkt;
            end
            S_ENT:
            begin
                e_re = 1'b1;
            end
            S_INS:
            begin
                e_we = 1'b1;
                pw_we = wr_reg;
                n_we = 1'b1;
                h_we = 1'b1;
                h_wd = PW'(ins_slot);
            end
            S_ENTW:
            begin
                // unlink on match
                if (mode_reg == MODE_DELETE && pg_rd == page_reg)
                begin
                    if (prev_reg == Nil)
                    begin
                        h_we = 1'b1;
                        h_wd = n_rd;
                    end
                    else
                    begin
                        n_we = 1'b1;
                        n_waddr = prev_reg[EW-1:0];
                        n_wd = n_rd;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cap_reg <= CapW'(1024);
            used_reg <= '0;
            recyc_reg <= '0;
            recyc_vld_reg <= 1'b0;
            rsp.valid <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            if (rsp.valid && rsp.ready)
                rsp.valid <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + BW'(1);
                    if (clr_reg == LastB)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg <= req.mode;
                        page_reg <= req.page_number;
                        pay_reg <= req.payload;
                        wr_reg <= req.write_payload;
                        sidx_reg <= req.slot_index;
                        rsp.status <= ST_OK;
                        rsp.hit <= 1'b0;
                        rsp.page_out <= '0;
                        rsp.payload_out <= '0;
                        if (req.mode == MODE_READ)
                            state_reg <= S_READW;
                        else if (req.mode == MODE_INSERT && used_reg >= limit)
                        begin
                            rsp.status <= ST_FULL;
                            state_reg <= S_OUT;
                        end
                        else
                            state_reg <= S_HASH;
                    end
                end
                S_HASH:
                    state_reg <= S_HEAD;
                S_HEAD:
                begin
                    bkt_reg <= hash_bkt;
                    if (hash_done)
                        state_reg <= S_HEADW;
                end
                S_HEADW:
                begin
                    cur_reg <= h_rd;
                    prev_reg <= Nil;
                    case (mode_reg)
                        MODE_INSERT: state_reg <= S_INS;
                        MODE_DELETE:
                        begin
                            if (h_rd == Nil)
                            begin
                                rsp.status <= ST_ABSENT;
                                state_reg <= S_OUT;
                            end
                            else if (recyc_vld_reg)
                            begin
                                rsp.status <= ST_DBL_DEL;
                                state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_ENT;
                        end
                        default:
                        begin
                            if (h_rd == Nil)
                            begin
                                rsp.status <= ST_MISS;
                                state_reg <= S_OUT;
                            end
                            else
                                state_reg <= S_ENT;
                        end
                    endcase
                end
                S_ENT:
                    state_reg <= S_ENTW;
                S_ENTW:
                begin
                    if (pg_rd == page_reg)
                    begin
                        if (mode_reg == MODE_DELETE)
                        begin
                            recyc_reg <= cur_reg[EW-1:0];
                            recyc_vld_reg <= 1'b1;
                            used_reg <= used_reg - PW'(1);
                        end
                        else
                        begin
                            rsp.hit <= 1'b1;
                            rsp.payload_out <= py_rd;
                        end
                        state_reg <= S_OUT;
                    end
                    else if (n_rd >= Nil)
                    begin
                        rsp.status <= (mode_reg == MODE_DELETE) ? ST_ABSENT : ST_MISS;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        prev_reg <= cur_reg;
                        cur_reg <= n_rd;
                        state_reg <= S_ENT;
                    end
                end
                S_INS:
                begin
                    recyc_vld_reg <= 1'b0;
                    used_reg <= used_reg + PW'(1);
                    state_reg <= S_OUT;
                end
                S_READW:
                begin
                    if (PW'(sidx_reg) >= used_reg || 32'(sidx_reg) >= ENTRIES)
                        rsp.status <= ST_RANGE;
                    else
                    begin
                        rsp.hit <= 1'b1;
                        rsp.page_out <= pg_rd;
                        rsp.payload_out <= py_rd;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp.valid)
                    begin
                        rsp.valid <= 1'b1;
                        rsp.used_out <= CapW'(used_reg);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/hpt_checker.sv @@
module hpt_checker
    import hpt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [StatusW-1:0] status,
    input logic              hit,
    input logic [CapW-1:0]   used_out
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(used_out))
        else $error("result dropped while stalled");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat accepted during work");
    a_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> status == ST_OK)
        else $error("hit with error status");
    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> used_out <= CapW'(1024))
        else $error("used count out of range");
endmodule

bind hashed_page_table hpt_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (rsp.status),
    .hit       (rsp.hit),
    .used_out  (rsp.used_out)
);
